// ----- rtl/adps_pkg.sv -----
// Shared types and constants for the antialiased disk pixel shader.
// No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps
package adps_pkg;

  // Radius limits and register reset values
  localparam int unsigned MaxRadius   = 512;
  localparam int unsigned RadiusW     = 10;
  localparam int unsigned SeamW       = 15;
  localparam int unsigned SeamMin     = 256;
  localparam int unsigned CoordW      = 10;
  localparam int unsigned ShadeW      = 3;

  // Square root datapath: radicand is s << 14 with s limited to 21 bits
  localparam int unsigned SumW        = 23;
  localparam int unsigned RadW        = 36;
  localparam int unsigned RootW       = RadW / 2;
  localparam int unsigned RemW        = RootW + 3;

  // Register file
  localparam int unsigned AddrW       = 4;
  localparam int unsigned DataW       = 32;

  typedef enum logic [1:0] {
    REG_RADIUS    = 2'd0,
    REG_SEAM      = 2'd1,
    REG_ANTIALIAS = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  // Sideband that rides the square root pipeline
  typedef struct packed {
    logic valid;
    logic covered;
  } side_t;

endpackage

// ----- rtl/antialiased_disk_pixel_shader_top.sv -----
// Top level of the antialiased disk pixel shader: register file, geometry
// stages, square root pipeline and shade stage. Depends on adps_pkg, adps_isqrt.
//
// Takes one pixel coordinate per clock while pixel_stall is low and returns
// covered and a 0..4 shade index for it, in order. The path is three geometry
// stages, the 18-stage bit-per-stage square root and the output register. A
// stall on the result side freezes the whole pipeline, so pixel_stall follows
// result_stall while a result is waiting. Registers (32-bit APB, byte
// addresses): 0x0 disk_radius (clamped to 1..512), 0x4 seam_width_q8 (Q7.8,
// raised to 1.0), 0x8 antialias_on. Write them only while the pipeline is
// empty.
`timescale 1ns / 1ps
module antialiased_disk_pixel_shader_top
  import adps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  // pixel beats
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  logic [CoordW-1:0] pixel_x,
  input  logic [CoordW-1:0] pixel_y,
  // result beats
  output logic              result_valid,
  input  logic              result_stall,
  output logic              covered,
  output logic [ShadeW-1:0] shade_index
);

  // Register file
  logic [RadiusW-1:0] disk_radius;
  logic [SeamW-1:0]   seam_width_q8;
  logic               antialias_on;
  reg_idx_t           widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_radius   <= RadiusW'(1);
      seam_width_q8 <= SeamW'(SeamMin);
      antialias_on  <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_RADIUS:    disk_radius   <= pwdata[RadiusW-1:0];
        REG_SEAM:      seam_width_q8 <= pwdata[SeamW-1:0];
        REG_ANTIALIAS: antialias_on  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_RADIUS:    prdata = DataW'(disk_radius);
      REG_SEAM:      prdata = DataW'(seam_width_q8);
      REG_ANTIALIAS: prdata = DataW'(antialias_on);
      default:       prdata = '0;
    endcase
  end

  // Effective radius and seam
  logic [RadiusW-1:0] r_eff;
  logic [SeamW-1:0]   seam_eff;
  logic [21:0]        lim4;   // 4*r*r, registered off the config

  always_comb begin
    if (disk_radius == '0) r_eff = RadiusW'(1);
    else if (disk_radius > RadiusW'(MaxRadius)) r_eff = RadiusW'(MaxRadius);
    else r_eff = disk_radius;
    seam_eff = (seam_width_q8 < SeamW'(SeamMin)) ? SeamW'(SeamMin) : seam_width_q8;
  end

  always_ff @(posedge clk) begin
    lim4 <= {20'(r_eff) * 20'(r_eff), 2'b00};
  end

  // Global pipeline enable
  logic advance;
  assign advance     = !(result_valid && result_stall);
  assign pixel_stall = !advance;

  // Stage 1: doubled offsets from the centre
  logic        v1;
  logic [10:0] a1, b1;
  logic [10:0] c2, px2, py2;

  assign c2  = {r_eff, 1'b0} - 11'd1;
  assign px2 = {pixel_x, 1'b0};
  assign py2 = {pixel_y, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (advance) v1 <= pixel_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a1 <= (c2 >= px2) ? c2 - px2 : px2 - c2;
      b1 <= (c2 >= py2) ? c2 - py2 : py2 - c2;
    end
  end

  // Stage 2: squares
  logic        v2;
  logic [21:0] asq2, bsq2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (advance) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      asq2 <= 22'(a1) * 22'(a1);
      bsq2 <= 22'(b1) * 22'(b1);
    end
  end

  // Stage 3: sum, inside test, radicand
  side_t           side3;
  logic [RadW-1:0] rad3;
  logic [SumW-1:0] s2;

  assign s2 = SumW'(asq2) + SumW'(bsq2);

  always_ff @(posedge clk) begin
    if (rst) side3.valid <= 1'b0;
    else if (advance) side3.valid <= v2;
    if (advance) begin
      side3.covered <= (s2 <= SumW'(lim4));
      rad3          <= {1'b0, s2[20:0], 14'd0};
    end
  end

  // Square root pipeline
  side_t            side_q;
  logic [RootW-1:0] dist_q8;

  adps_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .side_in  (side3),
    .radicand (rad3),
    .side_out (side_q),
    .root     (dist_q8)
  );

  // Shade stage: compare 8*(seam-e) against odd multiples of the seam
  logic [RootW-1:0]  rq, e, seam_x, n8;
  logic [RootW-1:0]  seam3, seam5, seam7;
  logic              in_seam;
  logic [ShadeW-1:0] shade_calc;

  always_comb begin
    rq      = {r_eff, 8'd0};
    e       = (rq >= dist_q8) ? rq - dist_q8 : '0;
    seam_x  = RootW'(seam_eff);
    seam3   = RootW'(seam_x + {seam_x[RootW-2:0], 1'b0});
    seam5   = RootW'(seam_x + {seam_x[RootW-3:0], 2'b00});
    seam7   = RootW'({seam_x[RootW-4:0], 3'b000} - seam_x);
    in_seam = (e < seam_x);
    n8      = {RootW'(seam_x - e)} << 3;
    shade_calc = ShadeW'(n8 >= seam_x) + ShadeW'(n8 >= seam3)
               + ShadeW'(n8 >= seam5) + ShadeW'(n8 >= seam7);
    if (!(side_q.covered && antialias_on && in_seam)) shade_calc = '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (advance) result_valid <= side_q.valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      covered     <= side_q.covered;
      shade_index <= shade_calc;
    end
  end

  // Checks
  a_uncov_dark: assert property (@(posedge clk) disable iff (rst)
    result_valid && !covered |-> shade_index == '0)
    else $error("uncovered pixel with nonzero shade");

  a_shade_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> shade_index <= ShadeW'(4))
    else $error("shade index above 4");

  a_hard_mode: assert property (@(posedge clk) disable iff (rst)
    result_valid && !antialias_on |-> shade_index == '0)
    else $error("shade in hard mode");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(shade_index)
    && $stable(covered))
    else $error("stalled result changed");

endmodule

// ----- rtl/adps_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on adps_pkg.
`timescale 1ns / 1ps
module adps_isqrt
  import adps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  side_t            side_in,
  input  logic [RadW-1:0]  radicand,
  output side_t            side_out,
  output logic [RootW-1:0] root
);

  side_t            side_q [0:RootW];
  logic [RadW-1:0]  rad_q  [0:RootW];
  logic [RemW-1:0]  rem_q  [0:RootW];
  logic [RootW-1:0] root_q [0:RootW];

  // Stage 0 is the input itself
  assign side_q[0] = side_in;
  assign rad_q[0]  = radicand;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic            fits;

    // bring down the next two radicand bits and try a one digit
    assign rem_sh = {rem_q[i][RemW-3:0], rad_q[i][RadW-1 -: 2]};
    assign trial  = {1'b0, root_q[i], 2'b01};
    assign fits   = (rem_sh >= trial);

    // valid is reset, the data travels with it
    always_ff @(posedge clk) begin
      if (rst) side_q[i+1].valid <= 1'b0;
      else if (advance) side_q[i+1].valid <= side_q[i].valid;
      if (advance) begin
        side_q[i+1].covered <= side_q[i].covered;
        rad_q[i+1]          <= {rad_q[i][RadW-3:0], 2'b00};
        rem_q[i+1]          <= fits ? rem_sh - trial : rem_sh;
        root_q[i+1]         <= {root_q[i][RootW-2:0], fits};
      end
    end
  end

  assign side_out = side_q[RootW];
  assign root     = root_q[RootW];

endmodule
